[sv/smf_pkg.sv]
`timescale 1ns / 1ps
package smf_pkg;

    localparam int HISTORY_DEPTH  = 256;
    localparam int LOW_TAPS       = 125;
    localparam int HIGH_TAPS      = 33;
    localparam int TAP_TABLE_SIZE = 128;
    localparam int LP_DEFINED     = 125;
    localparam int HP_DEFINED     = 33;

    localparam int HIST_AW = $clog2(HISTORY_DEPTH);
    localparam int TAP_W   = $clog2(TAP_TABLE_SIZE);

    localparam logic [TAP_W-1:0] LOW_LAST  = TAP_W'(LOW_TAPS - 1);
    localparam logic [TAP_W-1:0] HIGH_LAST = TAP_W'(HIGH_TAPS - 1);

    typedef logic signed [15:0] sample_t;
    typedef logic signed [15:0] coef_t;
    typedef logic signed [31:0] acc_t;
    typedef logic [HIST_AW-1:0] hist_addr_t;
    typedef logic [TAP_W-1:0]   tap_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic     capture;
        logic     issue;
        tap_idx_t tap;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        logic expect_left;
        logic use_low;
        logic pipe_busy;
    } status_t;

    localparam coef_t LP_COEF [LP_DEFINED] = '{
        -16'sd2, -16'sd1, 16'sd0, 16'sd0, 16'sd2, 16'sd3, 16'sd6, 16'sd8, 16'sd11, 16'sd14,
        16'sd17, 16'sd19, 16'sd19, 16'sd18, 16'sd14, 16'sd8, 16'sd0, -16'sd11, -16'sd23,
        -16'sd36, -16'sd49, -16'sd61, -16'sd69, -16'sd73, -16'sd70, -16'sd61, -16'sd45,
        -16'sd21, 16'sd10, 16'sd46, 16'sd84, 16'sd123, 16'sd157, 16'sd184, 16'sd199,
        16'sd199, 16'sd182, 16'sd146, 16'sd90, 16'sd17, -16'sd71, -16'sd168, -16'sd267,
        -16'sd360, -16'sd438, -16'sd492, -16'sd513, -16'sd492, -16'sd424, -16'sd305,
        -16'sd132, 16'sd91, 16'sd360, 16'sd666, 16'sd998, 16'sd1343, 16'sd1686, 16'sd2010,
        16'sd2302, 16'sd2545, 16'sd2728, 16'sd2842, 16'sd2880, 16'sd2842, 16'sd2728,
        16'sd2545, 16'sd2302, 16'sd2010, 16'sd1686, 16'sd1343, 16'sd998, 16'sd666,
        16'sd360, 16'sd91, -16'sd132, -16'sd305, -16'sd424, -16'sd492, -16'sd513,
        -16'sd492, -16'sd438, -16'sd360, -16'sd267, -16'sd168, -16'sd71, 16'sd17, 16'sd90,
        16'sd146, 16'sd182, 16'sd199, 16'sd199, 16'sd184, 16'sd157, 16'sd123, 16'sd84,
        16'sd46, 16'sd10, -16'sd21, -16'sd45, -16'sd61, -16'sd70, -16'sd73, -16'sd69,
        -16'sd61, -16'sd49, -16'sd36, -16'sd23, -16'sd11, 16'sd0, 16'sd8, 16'sd14, 16'sd18,
        16'sd19, 16'sd19, 16'sd17, 16'sd14, 16'sd11, 16'sd8, 16'sd6, 16'sd3, 16'sd2,
        16'sd0, 16'sd0, -16'sd1, -16'sd2
    };

    localparam coef_t HP_COEF [HP_DEFINED] = '{
        -16'sd1043, 16'sd210, 16'sd320, 16'sd472, 16'sd620, 16'sd713, 16'sd698, 16'sd534,
        16'sd198, -16'sd311, -16'sd967, -16'sd1719, -16'sd2494, -16'sd3215, -16'sd3800,
        -16'sd4181, 16'sd28455, -16'sd4181, -16'sd3800, -16'sd3215, -16'sd2494,
        -16'sd1719, -16'sd967, -16'sd311, 16'sd198, 16'sd534, 16'sd698, 16'sd713,
        16'sd620, 16'sd472, 16'sd320, 16'sd210, -16'sd1043
    };

    function automatic coef_t lp_coef(input tap_idx_t idx);
        coef_t c;
        c = '0;
        if (int'(idx) < LP_DEFINED)
        begin
            c = LP_COEF[int'(idx)];
        end
        return c;
    endfunction

    function automatic coef_t hp_coef(input tap_idx_t idx);
        coef_t c;
        c = '0;
        if (int'(idx) < HP_DEFINED)
        begin
            c = HP_COEF[int'(idx)];
        end
        return c;
    endfunction

endpackage

[sv/smf_in_if.sv]
`timescale 1ns / 1ps
interface smf_in_if;
    logic            valid;
    logic            ready;
    smf_pkg::sample_t sample;
    logic            use_low_pass;

    modport source (output valid, output sample, output use_low_pass, input ready);
    modport sink   (input valid, input sample, input use_low_pass, output ready);
endinterface

[sv/smf_out_if.sv]
`timescale 1ns / 1ps
interface smf_out_if;
    logic          valid;
    logic          ready;
    smf_pkg::acc_t filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

[sv/smf_ctrl.sv]
`timescale 1ns / 1ps
module smf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             out_ready,
    output logic             out_valid,
    input  smf_pkg::status_t status,
    output smf_pkg::cmd_t    cmd
);

    smf_pkg::state_t   state_reg, state_next;
    smf_pkg::tap_idx_t cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    smf_pkg::tap_idx_t last_tap;
    logic              out_free;

    assign last_tap = status.use_low ? smf_pkg::LOW_LAST : smf_pkg::HIGH_LAST;
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smf_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        unique case (state_reg)
            smf_pkg::ST_IDLE:
            begin
                if (in_valid && !status.expect_left)
                begin
                    state_next = smf_pkg::ST_RUN;
                end
            end
            smf_pkg::ST_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == last_tap)
                begin
                    state_next = smf_pkg::ST_DRAIN;
                    cnt_next   = '0;
                end
            end
            smf_pkg::ST_DRAIN:
            begin
                if (!status.pipe_busy && out_free)
                begin
                    state_next = smf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = smf_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.issue    = 1'b0;
        cmd.tap      = cnt_reg;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            smf_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            smf_pkg::ST_RUN:
            begin
                cmd.issue = 1'b1;
            end
            smf_pkg::ST_DRAIN:
            begin
                cmd.load_out = !status.pipe_busy && out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[sv/smf_datapath.sv]
`timescale 1ns / 1ps
module smf_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  smf_pkg::cmd_t     cmd,
    input  smf_pkg::sample_t  sample,
    input  logic              use_low_pass,
    output smf_pkg::status_t  status,
    output smf_pkg::acc_t     filtered
);

    localparam int FILL_W = smf_pkg::HIST_AW + 1;
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(smf_pkg::HISTORY_DEPTH);
    localparam logic [FILL_W-1:0] DEPTH_W  = FILL_W'(smf_pkg::HISTORY_DEPTH);
    localparam smf_pkg::hist_addr_t WP_LAST =
        smf_pkg::HIST_AW'(smf_pkg::HISTORY_DEPTH - 1);

    smf_pkg::sample_t history [smf_pkg::HISTORY_DEPTH];

    logic                expect_left_reg, expect_left_next;
    smf_pkg::sample_t    held_reg, held_next;
    smf_pkg::hist_addr_t wp_reg, wp_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    smf_pkg::hist_addr_t newest_reg, newest_next;
    logic                sel_reg, sel_next;
    logic                v1_reg, v2_reg;
    logic                hit1_reg;

    smf_pkg::sample_t    rd_data_reg;
    smf_pkg::coef_t      coef_reg;
    smf_pkg::acc_t       prod_reg;
    smf_pkg::acc_t       acc_reg;
    smf_pkg::acc_t       filtered_reg;

    smf_pkg::sample_t    half;
    smf_pkg::sample_t    mono;
    logic                write_mono;
    logic [FILL_W-1:0]   diff;
    smf_pkg::hist_addr_t rd_addr;
    logic                hit;
    smf_pkg::coef_t      coef;

    assign half       = sample >>> 1;
    assign mono       = held_reg + half;
    assign write_mono = cmd.capture && !expect_left_reg;

    // tap i reads the slot i places behind the newest sample
    always_comb
    begin
        diff = {1'b0, newest_reg} - FILL_W'(cmd.tap);
        if (diff[FILL_W-1])
        begin
            diff = diff + DEPTH_W;
        end
        rd_addr = diff[smf_pkg::HIST_AW-1:0];
    end

    assign hit  = FILL_W'(cmd.tap) < fill_reg;
    assign coef = sel_reg ? smf_pkg::lp_coef(cmd.tap) : smf_pkg::hp_coef(cmd.tap);

    always_comb
    begin
        expect_left_next = expect_left_reg;
        held_next        = held_reg;
        wp_next          = wp_reg;
        fill_next        = fill_reg;
        newest_next      = newest_reg;
        sel_next         = sel_reg;
        if (cmd.capture)
        begin
            if (expect_left_reg)
            begin
                held_next        = half;
                expect_left_next = 1'b0;
            end
            else
            begin
                expect_left_next = 1'b1;
                newest_next      = wp_reg;
                sel_next         = use_low_pass;
                wp_next          = (wp_reg == WP_LAST) ? '0 : wp_reg + 1'b1;
                if (fill_reg != FILL_MAX)
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_left_reg <= 1'b1;
            held_reg        <= '0;
            wp_reg          <= '0;
            fill_reg        <= '0;
            newest_reg      <= '0;
            sel_reg         <= 1'b0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
        end
        else
        begin
            expect_left_reg <= expect_left_next;
            held_reg        <= held_next;
            wp_reg          <= wp_next;
            fill_reg        <= fill_next;
            newest_reg      <= newest_next;
            sel_reg         <= sel_next;
            v1_reg          <= cmd.issue;
            v2_reg          <= v1_reg;
        end
    end

    // history memory
    always_ff @(posedge clk)
    begin
        if (write_mono)
        begin
            history[wp_reg] <= mono;
        end
        rd_data_reg <= history[rd_addr];
    end

    // multiply-accumulate pipeline
    always_ff @(posedge clk)
    begin
        coef_reg <= coef;
        hit1_reg <= hit;
        prod_reg <= hit1_reg ?
                    (smf_pkg::acc_t'(rd_data_reg) * smf_pkg::acc_t'(coef_reg)) : '0;
        if (write_mono)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
        if (cmd.load_out)
        begin
            filtered_reg <= acc_reg;
        end
    end

    assign status.expect_left = expect_left_reg;
    assign status.use_low     = sel_reg;
    assign status.pipe_busy   = v1_reg || v2_reg;
    assign filtered           = filtered_reg;

endmodule

[sv/stereo_mono_fir_filter.sv]
`timescale 1ns / 1ps
// Stereo to mono FIR filter. Samples arrive left then right; each is halved by
// an arithmetic shift and the pair is summed into a mono sample that enters a
// 256-entry history (zero after reset, tracked by a fill count, so no clearing
// pass). A right sample starts one multiply-accumulate unit that walks 125
// low-pass or 33 high-pass taps, tap 0 on the newest sample, one tap per cycle
// through the single history read port; the 32-bit wrapping sum is emitted as
// one output transaction. A left sample gives no output; after a right sample
// the input is held off while the taps are walked and the pipeline drains,
// longer only while an earlier result still waits on the output register.
module stereo_mono_fir_filter (
    input  logic      clk,
    input  logic      rst_n,
    smf_in_if.sink    din,
    smf_out_if.source dout
);

    smf_pkg::cmd_t    cmd;
    smf_pkg::status_t status;

    smf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (din.valid),
        .in_ready  (din.ready),
        .out_ready (dout.ready),
        .out_valid (dout.valid),
        .status    (status),
        .cmd       (cmd)
    );

    smf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sample       (din.sample),
        .use_low_pass (din.use_low_pass),
        .status       (status),
        .filtered     (dout.filtered)
    );

endmodule
